@@ rtl/pcm_voice_mixer_assert.svh @@
// assertion macros for the pcm voice mixer
`ifndef PCM_VOICE_MIXER_ASSERT_SVH
`define PCM_VOICE_MIXER_ASSERT_SVH
`define PVM_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define PVM_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/pvm_pkg.sv @@
// ----------------------------------------------------------------------------
// pvm_pkg
// shared types and constants of the pcm voice mixer
// ----------------------------------------------------------------------------
`default_nettype none
package pvm_pkg;
    localparam int VOICES      = 16;
    localparam int SOUND_SLOTS = 64;
    localparam int STORE_WORDS = 65536;
    localparam int VW = $clog2(VOICES);
    localparam int SW = $clog2(SOUND_SLOTS);
    localparam int AW = $clog2(STORE_WORDS);
    localparam int POSW = 17;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_PLAY = 3'd1, OP_PLAY_FREE = 3'd2, OP_STOP = 3'd3,
        OP_STOP_ALL = 3'd4, OP_WR_SAMPLE = 3'd5, OP_WR_SOUND = 3'd6, OP_NONE = 3'd7
    } op_t;

    typedef struct packed {
        op_t          op;
        logic [3:0]   channel_index;
        logic [5:0]   sound_index;
        logic [7:0]   volume;
        logic [15:0]  sample_address;
        logic [15:0]  sample_value;
        logic [15:0]  sound_start;
        logic [15:0]  sound_frames;
        logic         sound_stereo;
        logic         sound_loaded;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_FREE, ST_VLOAD, ST_RD0, ST_RD1, ST_MUL0, ST_MUL1,
        ST_ACC, ST_NEXT, ST_OUT
    } state_t;

    function automatic logic signed [31:0] clip16(input logic signed [31:0] v);
        if (v > 32'sd32767) return 32'sd32767;
        else if (v < -32'sd32768) return -32'sd32768;
        else return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/pvm_front.sv @@
// ----------------------------------------------------------------------------
// pvm_front
// two-entry command queue
// ----------------------------------------------------------------------------
`default_nettype none
module pvm_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pvm_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output pvm_pkg::cmd_t      q_cmd
);
    import pvm_pkg::*;
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/pvm_back.sv @@
// ----------------------------------------------------------------------------
// pvm_back
// command sequencer with voice walk and shared multiply-accumulate
// ----------------------------------------------------------------------------
`default_nettype none
module pvm_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire pvm_pkg::cmd_t q_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_data
);
    import pvm_pkg::*;
    logic [15:0]     store [STORE_WORDS];
    logic [15:0]     t_start [SOUND_SLOTS];
    logic [15:0]     t_frames [SOUND_SLOTS];
    logic            t_stereo [SOUND_SLOTS];
    logic            t_valid_reg [SOUND_SLOTS];
    logic            v_play_reg [VOICES];
    logic [POSW-1:0] v_pos_reg [VOICES];
    logic [SW-1:0]   v_snd_reg [VOICES];
    logic [7:0]      v_gain_reg [VOICES];

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic          tv_reg;
    logic [VW-1:0] vi_reg;
    logic [15:0]   ts_reg, tf_reg;
    logic          tst_reg, act_reg;
    logic [AW-1:0] addr_reg;
    logic [15:0]   rd_reg, s0_reg;
    logic signed [31:0] left_reg, right_reg, p0_reg, p1_reg;
    logic [31:0]   out_reg;
    logic          out_v_reg;
    logic [VW-1:0] fv;
    logic          ffound;
    logic          last_v;
    logic [POSW-1:0] pos;
    logic [POSW+1:0] a2;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign last_v = (vi_reg == VW'(VOICES - 1));
    assign pos = v_pos_reg[vi_reg];
    assign a2 = {2'b0, pos} << tst_reg;

    always_comb begin
        fv = '0; ffound = 1'b0;
        for (int i = VOICES - 1; i >= VOICES / 2; i--) begin
            if (!v_play_reg[i]) begin
                fv = VW'(i); ffound = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_DECODE;
            ST_DECODE: state_next = (cmd_reg.op == OP_TICK) ? ST_VLOAD : ST_IDLE;
            ST_FREE:   state_next = ST_IDLE;
            ST_VLOAD:  state_next = ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_NEXT;
            ST_NEXT:   state_next = last_v ? ST_OUT : ST_VLOAD;
            ST_OUT:    if (!out_v_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
            tv_reg  <= t_valid_reg[q_cmd.sound_index[SW-1:0]];
        end
        if (state_reg == ST_DECODE) begin
            if (cmd_reg.op == OP_WR_SAMPLE)
                store[cmd_reg.sample_address[AW-1:0]] <= cmd_reg.sample_value;
            if (cmd_reg.op == OP_WR_SOUND) begin
                t_start[cmd_reg.sound_index[SW-1:0]]  <= cmd_reg.sound_start;
                t_frames[cmd_reg.sound_index[SW-1:0]] <= cmd_reg.sound_frames;
                t_stereo[cmd_reg.sound_index[SW-1:0]] <= cmd_reg.sound_stereo;
            end
        end
        if (state_reg == ST_VLOAD) begin
            ts_reg  <= t_start[v_snd_reg[vi_reg]];
            tf_reg  <= t_frames[v_snd_reg[vi_reg]];
            tst_reg <= t_stereo[v_snd_reg[vi_reg]];
        end
        if (state_reg == ST_RD0) begin
            act_reg  <= v_play_reg[vi_reg] && ({1'b0, tf_reg} > pos);
            addr_reg <= AW'({2'b0, ts_reg} + a2 + 19'(tst_reg));
            rd_reg   <= store[AW'({2'b0, ts_reg} + a2)];
        end
        if (state_reg == ST_RD1) begin
            s0_reg <= rd_reg;
            rd_reg <= store[addr_reg];
        end
        if (state_reg == ST_MUL0) begin
            p0_reg <= (32'(signed'(s0_reg)) * signed'({24'd0, v_gain_reg[vi_reg]})) / 128;
            p1_reg <= (32'(signed'(rd_reg)) * signed'({24'd0, v_gain_reg[vi_reg]})) / 128;
        end
        if (state_reg == ST_MUL1 && !tst_reg) begin
            p0_reg <= clip16(p0_reg);
            p1_reg <= clip16(p0_reg);
        end
        if (state_reg == ST_DECODE) begin
            left_reg <= '0; right_reg <= '0;
        end else if (state_reg == ST_ACC && act_reg) begin
            left_reg <= left_reg + p0_reg; right_reg <= right_reg + p1_reg;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            vi_reg <= '0;
            for (int i = 0; i < SOUND_SLOTS; i++) t_valid_reg[i] <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                v_play_reg[i] <= 1'b0; v_pos_reg[i] <= '0;
                v_snd_reg[i] <= '0; v_gain_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_v_reg && out_ready) out_v_reg <= 1'b0;
            if (state_reg == ST_DECODE) begin
                vi_reg <= '0;
                unique case (cmd_reg.op)
                    OP_PLAY: if (tv_reg && cmd_reg.channel_index < 4'(VOICES / 2)) begin
                        v_play_reg[cmd_reg.channel_index[VW-1:0]] <= 1'b1;
                        v_pos_reg[cmd_reg.channel_index[VW-1:0]]  <= '0;
                        v_snd_reg[cmd_reg.channel_index[VW-1:0]]  <= cmd_reg.sound_index[SW-1:0];
                        v_gain_reg[cmd_reg.channel_index[VW-1:0]] <= cmd_reg.volume;
                    end
                    OP_PLAY_FREE: if (tv_reg && ffound) begin
                        v_play_reg[fv] <= 1'b1; v_pos_reg[fv] <= '0;
                        v_snd_reg[fv] <= cmd_reg.sound_index[SW-1:0];
                        v_gain_reg[fv] <= cmd_reg.volume;
                    end
                    OP_STOP: if (cmd_reg.channel_index < 4'(VOICES / 2))
                        v_play_reg[cmd_reg.channel_index[VW-1:0]] <= 1'b0;
                    OP_STOP_ALL: for (int i = 0; i < VOICES; i++) v_play_reg[i] <= 1'b0;
                    OP_WR_SOUND: t_valid_reg[cmd_reg.sound_index[SW-1:0]] <= cmd_reg.sound_loaded;
                    default: ;
                endcase
            end
            if (state_reg == ST_NEXT) begin
                if (v_play_reg[vi_reg]) begin
                    v_pos_reg[vi_reg] <= pos + 1'b1;
                    if (!act_reg) v_play_reg[vi_reg] <= 1'b0;
                end
                vi_reg <= vi_reg + 1'b1;
            end
            if (state_reg == ST_OUT && !out_v_reg) begin
                out_v_reg <= 1'b1;
                out_reg <= {16'(clip16(right_reg)), 16'(clip16(left_reg))};
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/pcm_voice_mixer.sv @@
// ----------------------------------------------------------------------------
// pcm_voice_mixer
// mixes up to 16 pcm voices from a sample store into stereo frames
// ----------------------------------------------------------------------------
// s_ beats carry one command each; a tick command returns one m_ beat with
// left and right samples, other commands return nothing.
// a two-beat queue takes commands while the back end works.
// the back end handles a non-tick command in its decode state; a tick walks all
// 16 voices in turn through the states vload, rd0, rd1, mul0, mul1, acc and next,
// reading the store through one read port, and then registers its frame; the
// back end takes no new command until the tick is through.
// reset stops all voices and marks every sound entry unloaded.
// when m_tready is low the finished frame is held; the back end keeps taking
// commands and waits only when the next frame is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module pcm_voice_mixer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode, channel_index, sound_index, volume, sample_address, sample_value,
    // sound_start, sound_frames, sound_stereo, sound_loaded, zero fill
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // left_out, right_out
    output logic [31:0]      m_tdata
);
    import pvm_pkg::*;
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    assign in_cmd.op             = op_t'(s_tdata[2:0]);
    assign in_cmd.channel_index  = s_tdata[6:3];
    assign in_cmd.sound_index    = s_tdata[12:7];
    assign in_cmd.volume         = s_tdata[20:13];
    assign in_cmd.sample_address = s_tdata[36:21];
    assign in_cmd.sample_value   = s_tdata[52:37];
    assign in_cmd.sound_start    = s_tdata[68:53];
    assign in_cmd.sound_frames   = s_tdata[84:69];
    assign in_cmd.sound_stereo   = s_tdata[85];
    assign in_cmd.sound_loaded   = s_tdata[86];

    pvm_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd, .q_valid, .q_ready, .q_cmd);
    pvm_back u_back (.aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata));
endmodule
`default_nettype wire

@@ rtl/pcm_voice_mixer_checker.sv @@
// ----------------------------------------------------------------------------
// pcm_voice_mixer_checker
// port-level checks of the pcm voice mixer
// ----------------------------------------------------------------------------
`default_nettype none
`include "pcm_voice_mixer_assert.svh"
module pcm_voice_mixer_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [87:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    `PVM_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PVM_ASSERT_IMP(a_known, aclk, aresetn, m_tvalid, !$isunknown(m_tdata))
    `PVM_ASSERT_NXT(a_rst, aclk, 1'b1, !aresetn, !m_tvalid && s_tready)
endmodule
bind pcm_voice_mixer pcm_voice_mixer_checker u_checker (.*);
`default_nettype wire
